[sv/lsfa_pkg.sv]
// Shared types, constants and the color palette for the LED stack fill animator.
// No dependencies; every other file refers to it by scoped names.
package lsfa_pkg;

  // Strip size limit and derived widths
  localparam int MAX_LEDS     = 256;
  localparam int POS_W        = $clog2(MAX_LEDS);
  localparam int CNT_W        = (POS_W + 1 > 9) ? POS_W + 1 : 9;
  localparam int PALETTE_SIZE = 10;
  localparam int PAL_W        = 4;

  // Field widths
  localparam int LED_COUNT_W = 9;
  localparam int FADE_W      = 16;
  localparam int RGB_W       = 24;
  localparam int CH_W        = 8;
  localparam int IDX_W       = 8;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_TIME   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_COLOR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANDOM_MODE = 2'd3;

  // Reset values
  localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST = 9'd256;
  localparam logic [FADE_W-1:0]      FADE_RST      = 16'd250;
  localparam logic [RGB_W-1:0]       COLOR_RST     = 24'h00FF00;

  // One tick's work: one or two LED writes
  typedef struct packed {
    logic              dual;
    logic [POS_W-1:0]  pos0;
    logic [RGB_W-1:0]  col0;
    logic [POS_W-1:0]  pos1;
    logic [RGB_W-1:0]  col1;
    logic [FADE_W-1:0] fade;
  } cmd_t;

  // Stack color palette
  function automatic logic [RGB_W-1:0] palette(input logic [PAL_W-1:0] idx);
    logic [RGB_W-1:0] c;
    case (idx)
      4'd0:    c = 24'hFF0000;
      4'd1:    c = 24'hFF7F00;
      4'd2:    c = 24'hFFFF00;
      4'd3:    c = 24'h00FF00;
      4'd4:    c = 24'h00FFFF;
      4'd5:    c = 24'h0000FF;
      4'd6:    c = 24'hFF00FF;
      4'd7:    c = 24'hFF007F;
      4'd8:    c = 24'hFFFFFF;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

  // Top position for a programmed LED count, saturated to 1..MAX_LEDS
  function automatic logic [POS_W-1:0] top_pos(input logic [LED_COUNT_W-1:0] cnt);
    logic [CNT_W-1:0] n;
    n = CNT_W'(cnt);
    if (n == '0) n = CNT_W'(1);
    if (n > CNT_W'(MAX_LEDS)) n = CNT_W'(MAX_LEDS);
    return POS_W'(n - CNT_W'(1));
  endfunction

endpackage

[sv/lsfa_front.sv]
// Front end: configuration registers, animation state, and classification of
// each tick into a one- or two-write command. Depends on lsfa_pkg.
module lsfa_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lsfa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lsfa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lsfa_pkg::RGB_W-1:0]    random_rgb_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output lsfa_pkg::cmd_t                cmd_o
);

  // Configuration registers
  logic [lsfa_pkg::LED_COUNT_W-1:0] led_count_q;
  logic [lsfa_pkg::FADE_W-1:0]      fade_time_q;
  logic [lsfa_pkg::RGB_W-1:0]       base_color_q;
  logic                             random_mode_q;

  // Animation state
  logic [lsfa_pkg::POS_W-1:0] stack_q, stack_d;
  logic [lsfa_pkg::POS_W-1:0] fall_q, fall_d;
  logic [lsfa_pkg::POS_W-1:0] tail_q, tail_d;
  logic [lsfa_pkg::POS_W-1:0] clear_q, clear_d;
  logic [lsfa_pkg::PAL_W-1:0] pal_q, pal_d;
  logic [lsfa_pkg::RGB_W-1:0] color_q, color_d;

  logic [lsfa_pkg::POS_W-1:0] top;
  logic [lsfa_pkg::POS_W-1:0] new_top;
  logic [lsfa_pkg::POS_W-1:0] fall_dec;
  logic [lsfa_pkg::PAL_W-1:0] pal_next;
  logic [lsfa_pkg::RGB_W-1:0] color_next;
  logic                       tail_hit;

  assign top        = lsfa_pkg::top_pos(led_count_q);
  assign new_top    = lsfa_pkg::top_pos(cfg_data_i[lsfa_pkg::LED_COUNT_W-1:0]);
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Next stack color
  assign pal_next   = (pal_q >= lsfa_pkg::PAL_W'(lsfa_pkg::PALETTE_SIZE - 1)) ? '0
                      : pal_q + lsfa_pkg::PAL_W'(1);
  assign color_next = random_mode_q ? random_rgb_i : lsfa_pkg::palette(pal_next);

  assign fall_dec = (fall_q == '0) ? top : fall_q - lsfa_pkg::POS_W'(1);
  assign tail_hit = ({1'b0, tail_q} > ({1'b0, fall_q} + (lsfa_pkg::POS_W + 1)'(1)));

  // Classify the tick and compute the state it leaves
  always_comb begin
    stack_d = stack_q;
    fall_d  = fall_q;
    tail_d  = tail_q;
    clear_d = clear_q;
    pal_d   = pal_q;
    color_d = color_q;
    cmd_o.dual = 1'b0;
    cmd_o.pos0 = clear_q;
    cmd_o.col0 = base_color_q;
    cmd_o.pos1 = fall_dec;
    cmd_o.col1 = color_q;
    cmd_o.fade = fade_time_q;
    if (fall_q == stack_q) begin
      // Clearing phase: one base-color write per tick, top down
      if (clear_q == '0) begin
        clear_d = top;
        stack_d = '0;
        color_d = color_next;
        if (!random_mode_q) pal_d = pal_next;
      end else begin
        clear_d = clear_q - lsfa_pkg::POS_W'(1);
      end
    end else begin
      // Falling phase: optional trailing clear, then the lit LED
      if (tail_hit) begin
        cmd_o.dual = 1'b1;
        cmd_o.pos0 = tail_q;
        tail_d = (tail_q == '0) ? top : tail_q - lsfa_pkg::POS_W'(1);
      end else begin
        cmd_o.pos0 = fall_dec;
        cmd_o.col0 = color_q;
      end
      fall_d = fall_dec;
      // Landing on the stack top
      if (fall_dec == stack_q) begin
        fall_d  = top;
        tail_d  = top;
        stack_d = (stack_q >= top) ? '0 : stack_q + lsfa_pkg::POS_W'(1);
        color_d = color_next;
        if (!random_mode_q) pal_d = pal_next;
      end
    end
  end

  // Hold configuration and state; a led_count write restarts the positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q   <= lsfa_pkg::LED_COUNT_RST;
      fade_time_q   <= lsfa_pkg::FADE_RST;
      base_color_q  <= '0;
      random_mode_q <= 1'b0;
      stack_q       <= '0;
      fall_q        <= lsfa_pkg::top_pos(lsfa_pkg::LED_COUNT_RST);
      tail_q        <= lsfa_pkg::top_pos(lsfa_pkg::LED_COUNT_RST);
      clear_q       <= lsfa_pkg::top_pos(lsfa_pkg::LED_COUNT_RST);
      pal_q         <= '0;
      color_q       <= lsfa_pkg::COLOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lsfa_pkg::REG_LED_COUNT: begin
          led_count_q <= cfg_data_i[lsfa_pkg::LED_COUNT_W-1:0];
          stack_q     <= '0;
          fall_q      <= new_top;
          tail_q      <= new_top;
          clear_q     <= new_top;
        end
        lsfa_pkg::REG_FADE_TIME:   fade_time_q   <= cfg_data_i[lsfa_pkg::FADE_W-1:0];
        lsfa_pkg::REG_BASE_COLOR:  base_color_q  <= cfg_data_i[lsfa_pkg::RGB_W-1:0];
        lsfa_pkg::REG_RANDOM_MODE: random_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end else if (push_o) begin
      stack_q <= stack_d;
      fall_q  <= fall_d;
      tail_q  <= tail_d;
      clear_q <= clear_d;
      pal_q   <= pal_d;
      color_q <= color_d;
    end
  end

endmodule

[sv/lsfa_queue.sv]
// Two-entry command queue between the front and back ends.
// Depends on lsfa_pkg for the command type.
module lsfa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lsfa_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output lsfa_pkg::cmd_t cmd_o
);

  lsfa_pkg::cmd_t slot_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = slot_q[rd_q];

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= cmd_i;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[sv/lsfa_back.sv]
// Back end: expands each queued command into LED write transactions through
// an output register. Depends on lsfa_pkg.
module lsfa_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  lsfa_pkg::cmd_t              cmd_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [lsfa_pkg::IDX_W-1:0]  led_index_o,
  output logic [lsfa_pkg::CH_W-1:0]   red_o,
  output logic [lsfa_pkg::CH_W-1:0]   green_o,
  output logic [lsfa_pkg::CH_W-1:0]   blue_o,
  output logic [lsfa_pkg::FADE_W-1:0] fade_ms_o,
  output logic                        last_o
);

  logic                         valid_q;
  logic                         second_q;
  logic                         load;
  logic [lsfa_pkg::POS_W-1:0]   pos_sel;
  logic [lsfa_pkg::RGB_W-1:0]   col_sel;
  logic [lsfa_pkg::POS_W+lsfa_pkg::IDX_W-1:0] pos_ext;
  logic [lsfa_pkg::IDX_W-1:0]   idx_q;
  logic [lsfa_pkg::RGB_W-1:0]   col_q;
  logic [lsfa_pkg::FADE_W-1:0]  fade_q;
  logic                         last_q;
  logic                         last_sel;

  assign load     = q_valid_i && (!valid_q || out_ready_i);
  assign last_sel = !cmd_i.dual || second_q;
  assign pop_o    = load && last_sel;
  assign pos_sel  = second_q ? cmd_i.pos1 : cmd_i.pos0;
  assign col_sel  = second_q ? cmd_i.col1 : cmd_i.col0;
  assign pos_ext  = {{lsfa_pkg::IDX_W{1'b0}}, pos_sel};

  // Output handshake and write selection
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else if (load) begin
      valid_q  <= 1'b1;
      second_q <= !last_sel;
    end else if (out_ready_i) begin
      valid_q  <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      idx_q  <= pos_ext[lsfa_pkg::IDX_W-1:0];
      col_q  <= col_sel;
      fade_q <= cmd_i.fade;
      last_q <= last_sel;
    end
  end

  assign out_valid_o = valid_q;
  assign led_index_o = idx_q;
  assign red_o       = col_q[23:16];
  assign green_o     = col_q[15:8];
  assign blue_o      = col_q[7:0];
  assign fade_ms_o   = fade_q;
  assign last_o      = last_q;

endmodule

[sv/led_stack_fill_animator.sv]
// LED stack fill animator: an accepted tick is stored in the command queue and
// its first LED write is then loaded into the output register, which sends one
// write per cycle while out_ready_i is high, popping a two-write command with
// its second write. A two-entry queue lets ticks be taken while writes drain.
// Reset: 256 LEDs, 250 ms fade, black base, palette mode, green stack color.
module led_stack_fill_animator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lsfa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lsfa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lsfa_pkg::RGB_W-1:0]      random_rgb_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [lsfa_pkg::IDX_W-1:0]      led_index_o,
  output logic [lsfa_pkg::CH_W-1:0]       red_o,
  output logic [lsfa_pkg::CH_W-1:0]       green_o,
  output logic [lsfa_pkg::CH_W-1:0]       blue_o,
  output logic [lsfa_pkg::FADE_W-1:0]     fade_ms_o,
  output logic                            last_o
);

  logic           push, pop, q_full, q_valid;
  lsfa_pkg::cmd_t push_cmd, head_cmd;

  // Classify ticks
  lsfa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .random_rgb_i (random_rgb_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // Decouple front and back
  lsfa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  // Emit LED writes
  lsfa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .led_index_o (led_index_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .fade_ms_o   (fade_ms_o),
    .last_o      (last_o)
  );

endmodule

[tb/tb_led_stack_fill_animator.sv]
// Self-checking testbench for the LED stack fill animator.
// Depends on lsfa_pkg and led_stack_fill_animator; predicts every LED write in-line.
`timescale 1ns / 100ps

module tb_led_stack_fill_animator;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PRINTS  = 50;

  // One expected LED write
  typedef struct packed {
    logic [lsfa_pkg::IDX_W-1:0]  index;
    logic [lsfa_pkg::RGB_W-1:0]  rgb;
    logic [lsfa_pkg::FADE_W-1:0] fade;
    logic                        last;
  } led_write_t;

  // Stack colors in the order they are taken
  localparam logic [23:0] STACK_COLORS [10] = '{
    24'hFF0000, 24'hFF7F00, 24'hFFFF00, 24'h00FF00, 24'h00FFFF,
    24'h0000FF, 24'hFF00FF, 24'hFF007F, 24'hFFFFFF, 24'h000000
  };

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [lsfa_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [lsfa_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic [lsfa_pkg::RGB_W-1:0]      random_rgb_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic [lsfa_pkg::IDX_W-1:0]      led_index_o;
  logic [lsfa_pkg::CH_W-1:0]       red_o;
  logic [lsfa_pkg::CH_W-1:0]       green_o;
  logic [lsfa_pkg::CH_W-1:0]       blue_o;
  logic [lsfa_pkg::FADE_W-1:0]     fade_ms_o;
  logic                            last_o;

  // Shadow configuration and animation state
  logic [8:0]  strip_len;
  logic [15:0] fade_reg;
  logic [23:0] base_rgb;
  logic        rand_mode;
  int          stack_h;
  int          drop_pos;
  int          trail_pos;
  int          wipe_pos;
  int          pal_sel;
  logic [23:0] stack_rgb;

  led_write_t pending_writes[$];
  led_write_t head;
  int         error_count;
  int         cycle_count;
  bit         calm;

  led_stack_fill_animator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .random_rgb_i (random_rgb_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .led_index_o  (led_index_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .fade_ms_o    (fade_ms_o),
    .last_o       (last_o)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Animation predictor
  // ---------------------------------------------------------------------------

  // Highest position of the strip, count saturated to 1..MAX_LEDS
  function automatic int strip_top();
    int n;
    n = int'(strip_len);
    if (n < 1) n = 1;
    if (n > lsfa_pkg::MAX_LEDS) n = lsfa_pkg::MAX_LEDS;
    return n - 1;
  endfunction

  function automatic void restart_strip();
    drop_pos  = strip_top();
    trail_pos = drop_pos;
    wipe_pos  = drop_pos;
    stack_h   = 0;
  endfunction

  function automatic void next_stack_color(input logic [23:0] rnd);
    if (rand_mode) begin
      stack_rgb = rnd;
    end else begin
      pal_sel   = (pal_sel >= 9) ? 0 : pal_sel + 1;
      stack_rgb = STACK_COLORS[pal_sel];
    end
  endfunction

  function automatic void queue_write(input int pos, input logic [23:0] rgb, input bit fin);
    led_write_t w;
    w.index = 8'(pos);
    w.rgb   = rgb;
    w.fade  = fade_reg;
    w.last  = fin;
    pending_writes.push_back(w);
  endfunction

  // Work out the LED writes of one tick and advance the shadow state
  function automatic void animate_tick(input logic [23:0] rnd);
    int top;
    top = strip_top();
    // Stack full: wipe one LED from the top down
    if (drop_pos == stack_h) begin
      queue_write(wipe_pos, base_rgb, 1'b1);
      if (wipe_pos == 0) begin
        wipe_pos = top;
        stack_h  = 0;
        next_stack_color(rnd);
      end else begin
        wipe_pos--;
      end
      return;
    end
    // Clear the trailing end of the falling pair
    if (trail_pos > drop_pos + 1) begin
      queue_write(trail_pos, base_rgb, 1'b0);
      trail_pos = (trail_pos == 0) ? top : trail_pos - 1;
    end
    drop_pos = (drop_pos == 0) ? top : drop_pos - 1;
    queue_write(drop_pos, stack_rgb, 1'b1);
    // Land on the stack top
    if (drop_pos == stack_h) begin
      drop_pos  = top;
      trail_pos = top;
      stack_h++;
      next_stack_color(rnd);
      if (stack_h >= top + 1) stack_h = 0;
    end
  endfunction

  function automatic void shadow_write(input logic [1:0] idx, input logic [23:0] data);
    case (idx)
      lsfa_pkg::REG_LED_COUNT: begin
        strip_len = data[8:0];
        restart_strip();
      end
      lsfa_pkg::REG_FADE_TIME:   fade_reg  = data[15:0];
      lsfa_pkg::REG_BASE_COLOR:  base_rgb  = data;
      lsfa_pkg::REG_RANDOM_MODE: rand_mode = data[0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_PRINTS)
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // Compare each LED write transaction with the oldest expected write
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("unexpected LED write at index", 32'(led_index_o), 32'h0);
      end else begin
        head = pending_writes.pop_front();
        if (led_index_o !== head.index)
          report_mismatch("led_index", 32'(led_index_o), 32'(head.index));
        if (red_o !== head.rgb[23:16])
          report_mismatch("red", 32'(red_o), 32'(head.rgb[23:16]));
        if (green_o !== head.rgb[15:8])
          report_mismatch("green", 32'(green_o), 32'(head.rgb[15:8]));
        if (blue_o !== head.rgb[7:0])
          report_mismatch("blue", 32'(blue_o), 32'(head.rgb[7:0]));
        if (fade_ms_o !== head.fade)
          report_mismatch("fade_ms", 32'(fade_ms_o), 32'(head.fade));
        if (last_o !== head.last)
          report_mismatch("last", 32'(last_o), 32'(head.last));
      end
    end
  end

  // Receiver: random stall and accept bursts, always ready once calm
  initial begin
    int  burst;
    bit  level;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (calm) begin
        @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        level = ($urandom_range(0, 2) != 0);
        burst = level ? $urandom_range(1, 30) : $urandom_range(1, 18);
        repeat (burst) begin
          @(negedge clk_i);
          out_ready_i <= level;
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one tick and hold it until the transaction completes
  task automatic send_tick(input logic [23:0] rnd);
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    random_rgb_i <= rnd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    animate_tick(rnd);
  endtask

  // Random sender gap between ticks
  task automatic sender_pause();
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Drop valid and wait until every expected write has come out
  task automatic drain_writes();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
  endtask

  task automatic quiesce();
    drain_writes();
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [23:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    shadow_write(idx, data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly short strips so the wipe phase is reached often
  function automatic logic [8:0] pick_count();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 12) return 9'($urandom_range(1, 8));
    if (sel < 16) return 9'($urandom_range(9, 24));
    case ($urandom_range(0, 4))
      0:       return 9'd0;
      1:       return 9'd255;
      2:       return 9'd256;
      3:       return 9'($urandom_range(257, 510));
      default: return 9'd511;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration: long strip, falling pair with trailing clear
  task automatic test_reset_state();
    send_tick(24'h000000);
    send_tick(24'hFFFFFF);
    send_tick(24'h5A5A5A);
    send_tick(24'hA5A5A5);
  endtask

  // Zero and one LED: every tick wipes position zero and advances the color
  task automatic test_single_led();
    quiesce();
    set_reg(lsfa_pkg::REG_LED_COUNT, 24'd0);
    send_tick(24'h000000);
    send_tick(24'hFFFFFF);
    quiesce();
    set_reg(lsfa_pkg::REG_LED_COUNT, 24'd1);
    send_tick(24'h123456);
  endtask

  // Whole fill and wipe cycle with random colors and extreme registers
  task automatic test_full_cycle();
    quiesce();
    set_reg(lsfa_pkg::REG_LED_COUNT, 24'd3);
    set_reg(lsfa_pkg::REG_FADE_TIME, 24'd0);
    set_reg(lsfa_pkg::REG_BASE_COLOR, 24'hFFFFFF);
    set_reg(lsfa_pkg::REG_RANDOM_MODE, 24'd1);
    for (int k = 0; k < 7; k++) send_tick(k[0] ? 24'hFFFFFF : 24'h000000);
    quiesce();
    set_reg(lsfa_pkg::REG_LED_COUNT, 24'd2);
    set_reg(lsfa_pkg::REG_FADE_TIME, 24'd65535);
    set_reg(lsfa_pkg::REG_BASE_COLOR, 24'h000000);
    set_reg(lsfa_pkg::REG_RANDOM_MODE, 24'd0);
    repeat (4) send_tick(24'hFFFFFF);
  endtask

  // Counts above the strip size saturate to the largest strip
  task automatic test_oversize_count();
    quiesce();
    set_reg(lsfa_pkg::REG_LED_COUNT, 24'd511);
    send_tick(24'h0F0F0F);
    send_tick(24'hF0F0F0);
    quiesce();
    set_reg(lsfa_pkg::REG_LED_COUNT, 24'd257);
    send_tick(24'h00FF00);
  endtask

  // Random settings per phase, random ticks with random idling on both sides
  task automatic test_random_phases();
    logic [23:0] data;
    for (int ph = 0; ph < 16; ph++) begin
      quiesce();
      if (ph == 0 || $urandom_range(0, 1) == 1)
        set_reg(lsfa_pkg::REG_LED_COUNT, 24'(pick_count()));
      if ($urandom_range(0, 1) == 1) begin
        data = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 65535));
        set_reg(lsfa_pkg::REG_FADE_TIME, data);
      end
      if ($urandom_range(0, 1) == 1)
        set_reg(lsfa_pkg::REG_BASE_COLOR, 24'($urandom));
      if ($urandom_range(0, 1) == 1) begin
        data = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 1));
        set_reg(lsfa_pkg::REG_RANDOM_MODE, data);
      end
      repeat ($urandom_range(10, 34)) begin
        send_tick(24'($urandom));
        sender_pause();
      end
    end
  endtask

  // Sender holds off mid-animation until the block has no write in flight
  task automatic test_drain_pause();
    quiesce();
    set_reg(lsfa_pkg::REG_LED_COUNT, 24'd6);
    set_reg(lsfa_pkg::REG_RANDOM_MODE, 24'd0);
    repeat (10) begin
      send_tick(24'($urandom));
      sender_pause();
    end
    drain_writes();
    repeat (12) begin
      send_tick(24'($urandom));
      sender_pause();
    end
  endtask

  // Full rate: no idling on either side
  task automatic test_back_to_back();
    quiesce();
    calm = 1'b1;
    set_reg(lsfa_pkg::REG_LED_COUNT, 24'd5);
    set_reg(lsfa_pkg::REG_RANDOM_MODE, 24'd1);
    repeat (40) send_tick(24'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = lsfa_pkg::REG_LED_COUNT;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    random_rgb_i = '0;
    calm         = 1'b0;
    error_count  = 0;

    // Shadow state after reset
    strip_len = lsfa_pkg::LED_COUNT_RST;
    fade_reg  = lsfa_pkg::FADE_RST;
    base_rgb  = '0;
    rand_mode = 1'b0;
    pal_sel   = 0;
    stack_rgb = lsfa_pkg::COLOR_RST;
    restart_strip();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_single_led();
    test_full_cycle();
    test_oversize_count();
    test_random_phases();
    test_drain_pause();
    test_back_to_back();

    drain_writes();
    repeat (10) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/lsfa_pkg.sv
sv/lsfa_front.sv
sv/lsfa_queue.sv
sv/lsfa_back.sv
sv/led_stack_fill_animator.sv
tb/tb_led_stack_fill_animator.sv
